### rtl/interval_set_tracker_top_assert.svh
// Assertion macros shared by the interval set tracker RTL.
`ifndef INTERVAL_SET_TRACKER_TOP_ASSERT_SVH
`define INTERVAL_SET_TRACKER_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define IST_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define IST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// Types and codes shared by the interval set tracker modules.
// ----------------------------------------------------------------------------
package ist_pkg;

    localparam int unsigned OFS_W = 64;
    localparam int unsigned CFG_W = 6;

    typedef enum logic [2:0] {
        MODE_ADD      = 3'd0,
        MODE_REMOVE   = 3'd1,
        MODE_TRIM     = 3'd2,
        MODE_CONTAINS = 3'd3,
        MODE_COVERS   = 3'd4,
        MODE_POP      = 3'd5,
        MODE_CLEAR    = 3'd6,
        MODE_NONE     = 3'd7
    } mode_t;

    typedef struct packed {
        logic [2:0]       mode;
        logic [OFS_W-1:0] start_offset;
        logic [OFS_W-1:0] end_offset;
        logic             evict_lowest;
        logic [OFS_W-1:0] length_limit;
    } in_word_t;

    typedef struct packed {
        logic             status;
        logic             answer;
        logic [OFS_W-1:0] out_start;
        logic [OFS_W-1:0] out_end;
    } out_word_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,   // read entry at scan index
        ST_SCAN,      // evaluate entry during a scan
        ST_MERGE_RD,
        ST_MERGE,
        ST_SHIFT_RD,  // read entry that moves
        ST_SHIFT,     // write the moved entry
        ST_WRITE,     // write the final entry
        ST_DONE
    } state_t;

    // Memory request from the sequencer to the table.
    typedef struct packed {
        logic             we;
        logic [7:0]       waddr;
        logic [OFS_W-1:0] wstart;
        logic [OFS_W-1:0] wend;
        logic [7:0]       raddr;
    } mem_req_t;

endpackage

### rtl/ist_table.sv
// ----------------------------------------------------------------------------
// ist_table
// Interval storage: one synchronous memory of start/end pairs with a
// registered read port and one write port.
// ----------------------------------------------------------------------------
module ist_table #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic                       aclk,
    input  ist_pkg::mem_req_t          req,
    output logic [ist_pkg::OFS_W-1:0]  rd_start,
    output logic [ist_pkg::OFS_W-1:0]  rd_end
);

    logic [2*ist_pkg::OFS_W-1:0] mem [DEPTH];
    logic [2*ist_pkg::OFS_W-1:0] rd_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr[AW-1:0]] <= {req.wstart, req.wend};
        end
        rd_reg <= mem[req.raddr[AW-1:0]];
    end

    assign rd_start = rd_reg[2*ist_pkg::OFS_W-1:ist_pkg::OFS_W];
    assign rd_end   = rd_reg[ist_pkg::OFS_W-1:0];

endmodule

### rtl/ist_seq.sv
// ----------------------------------------------------------------------------
// ist_seq
// Operation sequencer: scans the sorted table one entry at a time, decides
// the edit, and moves entries up or down through the memory to compact the
// table or open a gap.
// ----------------------------------------------------------------------------
`include "interval_set_tracker_top_assert.svh"

module ist_seq #(
    parameter int unsigned DEPTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [ist_pkg::CFG_W-1:0] max_ranges,
    input  logic                      start,
    input  ist_pkg::in_word_t         cmd,
    output logic                      busy,
    output logic                      done,
    output ist_pkg::out_word_t        result,
    output ist_pkg::mem_req_t         req,
    input  logic [ist_pkg::OFS_W-1:0] rd_start,
    input  logic [ist_pkg::OFS_W-1:0] rd_end
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    // Shift plans used by the final phase.
    typedef enum logic [1:0] {
        SH_NONE,
        SH_DOWN,   // drop entries [dst,src) by moving later ones down
        SH_UP      // open a gap at ins_pos by moving entries up
    } shift_t;

    ist_pkg::state_t state_reg, state_next;
    ist_pkg::in_word_t cmd_reg, cmd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;       // scan index
    logic [CW-1:0] mrg_reg, mrg_next;       // merge index j
    logic [CW-1:0] src_reg, src_next;       // shift source
    logic [CW-1:0] dst_reg, dst_next;       // shift destination
    logic [CW-1:0] pos_reg, pos_next;       // position of final write
    shift_t        sh_reg, sh_next;
    logic [ist_pkg::OFS_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [ist_pkg::OFS_W-1:0] ws_reg, ws_next, we_reg, we_next;
    logic          wfin_reg, wfin_next;     // final write pending
    logic          after_reg, after_next;   // write before (0) or after (1) shift
    ist_pkg::out_word_t res_reg, res_next;

    logic [CW-1:0] limit;
    logic          at_end;

    always_comb begin
        if (32'(max_ranges) > DEPTH)
            limit = CW'(DEPTH);
        else
            limit = CW'(max_ranges);
    end

    assign busy   = (state_reg != ist_pkg::ST_IDLE);
    assign done   = (state_reg == ist_pkg::ST_DONE);
    assign result = res_reg;
    assign at_end = (idx_reg >= count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ist_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        cmd_reg   <= cmd_next;
        idx_reg   <= idx_next;
        mrg_reg   <= mrg_next;
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        pos_reg   <= pos_next;
        sh_reg    <= sh_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        ws_reg    <= ws_next;
        we_reg    <= we_next;
        wfin_reg  <= wfin_next;
        after_reg <= after_next;
        res_reg   <= res_next;
    end

    // Next state, datapath and memory requests.
    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        mrg_next   = mrg_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        pos_next   = pos_reg;
        sh_next    = sh_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        ws_next    = ws_reg;
        we_next    = we_reg;
        wfin_next  = wfin_reg;
        after_next = after_reg;
        res_next   = res_reg;
        req        = '0;
        case (state_reg)
            ist_pkg::ST_IDLE: begin
                if (start) begin
                    cmd_next   = cmd;
                    res_next   = '0;
                    idx_next   = '0;
                    sh_next    = SH_NONE;
                    wfin_next  = 1'b0;
                    after_next = 1'b0;
                    lo_next    = cmd.start_offset;
                    hi_next    = cmd.end_offset;
                    state_next = ist_pkg::ST_SCAN_RD;
                    case (cmd.mode)
                        ist_pkg::MODE_ADD, ist_pkg::MODE_REMOVE: begin
                            if (cmd.start_offset >= cmd.end_offset)
                                state_next = ist_pkg::ST_DONE;
                        end
                        ist_pkg::MODE_COVERS: begin
                            if (cmd.start_offset >= cmd.end_offset) begin
                                res_next.answer = 1'b1;
                                state_next = ist_pkg::ST_DONE;
                            end
                        end
                        ist_pkg::MODE_POP: begin
                            if (count_reg == '0 || cmd.length_limit == '0)
                                state_next = ist_pkg::ST_DONE;
                        end
                        ist_pkg::MODE_CLEAR: begin
                            count_next = '0;
                            state_next = ist_pkg::ST_DONE;
                        end
                        ist_pkg::MODE_NONE: begin
                            state_next = ist_pkg::ST_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            ist_pkg::ST_SCAN_RD: begin
                req.raddr = 8'(idx_reg);
                state_next = ist_pkg::ST_SCAN;
            end
            ist_pkg::ST_SCAN: begin
                req.raddr = 8'(idx_reg);
                state_next = ist_pkg::ST_DONE;
                case (cmd_reg.mode)
                    ist_pkg::MODE_CONTAINS: begin
                        if (!at_end && rd_end < cmd_reg.start_offset) begin
                            idx_next = idx_reg + 1'b1;
                            state_next = ist_pkg::ST_SCAN_RD;
                        end else if (!at_end) begin
                            res_next.answer = (rd_start <= cmd_reg.start_offset) &&
                                              (cmd_reg.start_offset < rd_end);
                        end
                    end
                    ist_pkg::MODE_COVERS: begin
                        if (!at_end && rd_end < cmd_reg.start_offset) begin
                            idx_next = idx_reg + 1'b1;
                            state_next = ist_pkg::ST_SCAN_RD;
                        end else if (!at_end) begin
                            res_next.answer = (rd_start <= cmd_reg.start_offset) &&
                                              (cmd_reg.end_offset <= rd_end);
                        end
                    end
                    ist_pkg::MODE_POP: begin
                        res_next.answer    = 1'b1;
                        res_next.out_start = rd_start;
                        if (rd_end - rd_start <= cmd_reg.length_limit) begin
                            res_next.out_end = rd_end;
                            dst_next   = '0;
                            src_next   = CW'(1);
                            sh_next    = SH_DOWN;
                            state_next = ist_pkg::ST_SHIFT_RD;
                        end else begin
                            res_next.out_end = rd_start + cmd_reg.length_limit;
                            ws_next    = rd_start + cmd_reg.length_limit;
                            we_next    = rd_end;
                            pos_next   = '0;
                            wfin_next  = 1'b1;
                            state_next = ist_pkg::ST_WRITE;
                        end
                    end
                    ist_pkg::MODE_TRIM: begin
                        if (!at_end && rd_end <= cmd_reg.start_offset) begin
                            idx_next = idx_reg + 1'b1;
                            state_next = ist_pkg::ST_SCAN_RD;
                        end else begin
                            // drop [0,idx) then clip the new first entry
                            dst_next  = '0;
                            src_next  = idx_reg;
                            sh_next   = SH_DOWN;
                            if (!at_end && rd_start < cmd_reg.start_offset) begin
                                ws_next   = cmd_reg.start_offset;
                                we_next   = rd_end;
                                pos_next  = idx_reg;
                                wfin_next = 1'b1;
                            end
                            state_next = ist_pkg::ST_WRITE;
                        end
                    end
                    ist_pkg::MODE_ADD: begin
                        if (!at_end && rd_end < cmd_reg.start_offset) begin
                            idx_next = idx_reg + 1'b1;
                            state_next = ist_pkg::ST_SCAN_RD;
                        end else if (!at_end && rd_start <= cmd_reg.end_offset) begin
                            // merge run begins at idx
                            if (rd_start < lo_reg) lo_next = rd_start;
                            if (rd_end > hi_reg)   hi_next = rd_end;
                            mrg_next   = idx_reg + 1'b1;
                            state_next = ist_pkg::ST_MERGE_RD;
                        end else if (count_reg >= limit &&
                                     (!cmd_reg.evict_lowest || count_reg == '0 ||
                                      idx_reg == '0)) begin
                            res_next.status = 1'b1;
                        end else if (count_reg >= limit) begin
                            // evict entry 0, insert at idx-1
                            dst_next   = '0;
                            src_next   = CW'(1);
                            sh_next    = SH_DOWN;
                            ws_next    = cmd_reg.start_offset;
                            we_next    = cmd_reg.end_offset;
                            pos_next   = idx_reg - 1'b1;
                            wfin_next  = 1'b1;
                            after_next = 1'b1;
                            idx_next   = idx_reg - 1'b1;
                            state_next = ist_pkg::ST_SHIFT_RD;
                        end else if (count_reg >= CW'(DEPTH)) begin
                            res_next.status = 1'b1;
                        end else begin
                            sh_next    = SH_UP;
                            src_next   = count_reg;
                            ws_next    = cmd_reg.start_offset;
                            we_next    = cmd_reg.end_offset;
                            pos_next   = idx_reg;
                            wfin_next  = 1'b1;
                            after_next = 1'b1;
                            state_next = ist_pkg::ST_SHIFT_RD;
                        end
                    end
                    ist_pkg::MODE_REMOVE: begin
                        if (!at_end && rd_end < cmd_reg.start_offset) begin
                            idx_next = idx_reg + 1'b1;
                            state_next = ist_pkg::ST_SCAN_RD;
                        end else if (!at_end && rd_start < cmd_reg.end_offset) begin
                            if (rd_start < cmd_reg.start_offset &&
                                rd_end > cmd_reg.end_offset) begin
                                // split: write lower part now
                                req.we     = 1'b1;
                                req.waddr  = 8'(idx_reg);
                                req.wstart = rd_start;
                                req.wend   = cmd_reg.start_offset;
                                if (count_reg >= limit || count_reg >= CW'(DEPTH)) begin
                                    res_next.status = 1'b1;
                                end else begin
                                    sh_next    = SH_UP;
                                    src_next   = count_reg;
                                    ws_next    = cmd_reg.end_offset;
                                    we_next    = rd_end;
                                    pos_next   = idx_reg + 1'b1;
                                    wfin_next  = 1'b1;
                                    after_next = 1'b1;
                                    state_next = ist_pkg::ST_SHIFT_RD;
                                end
                            end else if (rd_start < cmd_reg.start_offset) begin
                                req.we     = 1'b1;
                                req.waddr  = 8'(idx_reg);
                                req.wstart = rd_start;
                                req.wend   = cmd_reg.start_offset;
                                idx_next   = idx_reg + 1'b1;
                                state_next = ist_pkg::ST_SCAN_RD;
                            end else if (rd_end > cmd_reg.end_offset) begin
                                // clipped from below; later entries start past end
                                req.we     = 1'b1;
                                req.waddr  = 8'(idx_reg);
                                req.wstart = cmd_reg.end_offset;
                                req.wend   = rd_end;
                            end else begin
                                // fully covered: find end of covered run
                                mrg_next   = idx_reg + 1'b1;
                                state_next = ist_pkg::ST_MERGE_RD;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ist_pkg::ST_MERGE_RD: begin
                req.raddr = 8'(mrg_reg);
                state_next = ist_pkg::ST_MERGE;
            end
            ist_pkg::ST_MERGE: begin
                if (cmd_reg.mode == ist_pkg::MODE_ADD) begin
                    if (mrg_reg < count_reg && rd_start <= cmd_reg.end_offset) begin
                        if (rd_start < lo_reg) lo_next = rd_start;
                        if (rd_end > hi_reg)   hi_next = rd_end;
                        mrg_next   = mrg_reg + 1'b1;
                        state_next = ist_pkg::ST_MERGE_RD;
                    end else begin
                        ws_next    = lo_reg;
                        we_next    = hi_reg;
                        pos_next   = idx_reg;
                        wfin_next  = 1'b1;
                        dst_next   = idx_reg + 1'b1;
                        src_next   = mrg_reg;
                        sh_next    = SH_DOWN;
                        state_next = ist_pkg::ST_WRITE;
                    end
                end else begin
                    // remove: entries fully inside are dropped; a last
                    // partly covered one is clipped at its start
                    if (mrg_reg < count_reg && rd_start < cmd_reg.end_offset &&
                        rd_end <= cmd_reg.end_offset) begin
                        mrg_next   = mrg_reg + 1'b1;
                        state_next = ist_pkg::ST_MERGE_RD;
                    end else begin
                        if (mrg_reg < count_reg && rd_start < cmd_reg.end_offset) begin
                            ws_next   = cmd_reg.end_offset;
                            we_next   = rd_end;
                            pos_next  = mrg_reg;
                            wfin_next = 1'b1;
                        end
                        dst_next   = idx_reg;
                        src_next   = mrg_reg;
                        sh_next    = SH_DOWN;
                        state_next = ist_pkg::ST_WRITE;
                    end
                end
            end
            ist_pkg::ST_WRITE: begin
                // final write before a downward shift: its address is the
                // source or merge entry, which the shift then moves
                if (wfin_reg && !after_reg) begin
                    req.we     = 1'b1;
                    req.waddr  = 8'(pos_reg);
                    req.wstart = ws_reg;
                    req.wend   = we_reg;
                    wfin_next  = 1'b0;
                end
                if (sh_reg == SH_DOWN && src_reg != dst_reg)
                    state_next = ist_pkg::ST_SHIFT_RD;
                else if (wfin_reg && after_reg)
                    state_next = ist_pkg::ST_WRITE;
                else
                    state_next = ist_pkg::ST_DONE;
                if (after_reg && wfin_reg && sh_reg == SH_NONE) begin
                    req.we     = 1'b1;
                    req.waddr  = 8'(pos_reg);
                    req.wstart = ws_reg;
                    req.wend   = we_reg;
                    wfin_next  = 1'b0;
                    state_next = ist_pkg::ST_DONE;
                end
            end
            ist_pkg::ST_SHIFT_RD: begin
                if (sh_reg == SH_DOWN) begin
                    // An evicting add stops below its insert slot and keeps
                    // the count, since one entry leaves and one arrives.
                    if (src_reg >= count_reg || (after_reg && src_reg > pos_reg)) begin
                        if (!after_reg) count_next = dst_reg;
                        sh_next    = SH_NONE;
                        state_next = ist_pkg::ST_WRITE;
                    end else begin
                        req.raddr  = 8'(src_reg);
                        state_next = ist_pkg::ST_SHIFT;
                    end
                end else if (sh_reg == SH_UP) begin
                    if (src_reg <= pos_reg) begin
                        count_next = count_reg + 1'b1;
                        sh_next    = SH_NONE;
                        state_next = ist_pkg::ST_WRITE;
                    end else begin
                        req.raddr  = 8'(src_reg - 1'b1);
                        state_next = ist_pkg::ST_SHIFT;
                    end
                end else begin
                    state_next = ist_pkg::ST_WRITE;
                end
            end
            ist_pkg::ST_SHIFT: begin
                req.we     = 1'b1;
                req.wstart = rd_start;
                req.wend   = rd_end;
                if (sh_reg == SH_DOWN) begin
                    // downward shift writes at a destination that moves with the source
                    req.waddr = 8'(dst_reg);
                    src_next  = src_reg + 1'b1;
                    dst_next  = dst_reg + 1'b1;
                end else begin
                    req.waddr = 8'(src_reg);
                    src_next  = src_reg - 1'b1;
                end
                state_next = ist_pkg::ST_SHIFT_RD;
            end
            ist_pkg::ST_DONE: begin
                state_next = ist_pkg::ST_IDLE;
            end
            default: state_next = ist_pkg::ST_IDLE;
        endcase
    end

    `IST_ASSERT_IMP(a_count_max, aclk, aresetn, 1'b1, count_reg <= CW'(DEPTH),
        "interval count above table depth")
    `IST_ASSERT_NEXT(a_done_idle, aclk, aresetn, state_reg == ist_pkg::ST_DONE,
        state_reg == ist_pkg::ST_IDLE, "done not followed by idle")
    `IST_ASSERT_NEXT(a_clear, aclk, aresetn,
        start && !busy && cmd.mode == ist_pkg::MODE_CLEAR, count_reg == '0,
        "clear left entries")
    `IST_ASSERT_IMP(a_no_write_idle, aclk, aresetn, state_reg == ist_pkg::ST_IDLE,
        !req.we, "table written while idle")

endmodule

### rtl/interval_set_tracker_top.sv
// ----------------------------------------------------------------------------
// interval_set_tracker_top
// Sorted table of disjoint half-open intervals over 64-bit offsets.
// ----------------------------------------------------------------------------
//  Channel   Ports                       Direction
//  input     s_valid s_ready s_word      in   (one operation per word)
//  result    m_valid m_ready m_word      out  (one result per word)
//  config    cfg_we cfg_wdata            in   (max_ranges)
//
// An operation reads or moves table entries one at a time between one
// accepted word and the next, plus a final write; every step waits on the
// registered read of the table memory.
// Reset is synchronous and active low; the table needs no clearing pass.
// A new word is taken once the sequencer is idle and the result register
// is free or being drained.
`include "interval_set_tracker_top_assert.svh"

module interval_set_tracker_top #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [ist_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  ist_pkg::in_word_t         s_word,
    output logic                      m_valid,
    input  logic                      m_ready,
    output ist_pkg::out_word_t        m_word
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [ist_pkg::CFG_W-1:0] max_reg;
    logic                      mv_reg;
    ist_pkg::out_word_t        mw_reg;
    logic                      busy, done;
    ist_pkg::out_word_t        res;
    ist_pkg::mem_req_t         req;
    logic [ist_pkg::OFS_W-1:0] rd_start, rd_end;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) max_reg <= ist_pkg::CFG_W'(32);
        else if (cfg_we) max_reg <= cfg_wdata;
    end

    assign s_ready = !busy && (!mv_reg || m_ready);

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (done) begin
            mv_reg <= 1'b1;
        end else if (m_ready) begin
            mv_reg <= 1'b0;
        end
        if (done) mw_reg <= res;
    end

    assign m_valid = mv_reg;
    assign m_word  = mw_reg;

    ist_seq #(.DEPTH(TABLE_DEPTH)) u_seq (
        .aclk, .aresetn, .max_ranges(max_reg),
        .start(s_valid && s_ready), .cmd(s_word),
        .busy, .done, .result(res), .req, .rd_start, .rd_end
    );

    ist_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
        .aclk, .req, .rd_start, .rd_end
    );

    `IST_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, busy, !s_ready,
        "word accepted while busy")
    `IST_ASSERT_NEXT(a_done_valid, aclk, aresetn, done, m_valid,
        "result lost")
    `IST_ASSERT_IMP(a_done_free, aclk, aresetn, done, !m_valid || m_ready,
        "result overwritten")

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Interval set tracker testbench
// Runs directed and random operations on the interval table. A behavioral
// table model predicts every result, and a checker compares each word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [ist_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    ist_pkg::in_word_t s_word = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ist_pkg::out_word_t m_word;

    // Model of the table and its limit.
    logic [63:0] tbl_lo[DEPTH];
    logic [63:0] tbl_hi[DEPTH];
    int tbl_count;
    int tbl_limit_reg;
    ist_pkg::out_word_t expected_words[$];
    int fail_count = 0;
    int idle_cycles = 0;

    interval_set_tracker_top #(.TABLE_DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int table_limit();
        return tbl_limit_reg > DEPTH ? DEPTH : tbl_limit_reg;
    endfunction

    function automatic int first_reaching(logic [63:0] x);
        int i;
        i = 0;
        while (i < tbl_count && tbl_hi[i] < x) i++;
        return i;
    endfunction

    function automatic void drop_range(int a, int b);
        for (int k = b; k < tbl_count; k++) begin
            tbl_lo[a + k - b] = tbl_lo[k];
            tbl_hi[a + k - b] = tbl_hi[k];
        end
        tbl_count -= b - a;
    endfunction

    function automatic void open_slot(int i);
        for (int k = tbl_count; k > i; k--) begin
            tbl_lo[k] = tbl_lo[k - 1];
            tbl_hi[k] = tbl_hi[k - 1];
        end
        tbl_count++;
    endfunction

    function automatic logic table_add(logic [63:0] lo, logic [63:0] hi, logic evict);
        int i, j;
        if (lo >= hi) return 1'b0;
        i = first_reaching(lo);
        for (j = i; j < tbl_count && tbl_lo[j] <= hi; j++) begin
            if (tbl_lo[j] < lo) lo = tbl_lo[j];
            if (tbl_hi[j] > hi) hi = tbl_hi[j];
        end
        if (j > i) begin
            tbl_lo[i] = lo;
            tbl_hi[i] = hi;
            drop_range(i + 1, j);
            return 1'b0;
        end
        if (tbl_count >= table_limit()) begin
            if (!evict || tbl_count == 0 || i == 0) return 1'b1;
            drop_range(0, 1);
            i--;
        end
        if (tbl_count >= DEPTH) return 1'b1;
        open_slot(i);
        tbl_lo[i] = lo;
        tbl_hi[i] = hi;
        return 1'b0;
    endfunction

    function automatic logic table_remove(logic [63:0] lo, logic [63:0] hi);
        int i;
        logic [63:0] cs, ce;
        if (lo >= hi) return 1'b0;
        i = first_reaching(lo);
        while (i < tbl_count && tbl_lo[i] < hi) begin
            cs = tbl_lo[i];
            ce = tbl_hi[i];
            if (cs < lo && ce > hi) begin
                tbl_hi[i] = lo;
                if (tbl_count >= table_limit() || tbl_count >= DEPTH) return 1'b1;
                open_slot(i + 1);
                tbl_lo[i + 1] = hi;
                tbl_hi[i + 1] = ce;
                return 1'b0;
            end
            if (cs < lo) begin
                tbl_hi[i] = lo;
                i++;
            end else if (ce > hi) begin
                tbl_lo[i] = hi;
                i++;
            end else begin
                drop_range(i, i + 1);
            end
        end
        return 1'b0;
    endfunction

    // Applies one operation to the model and returns the result word.
    function automatic ist_pkg::out_word_t predict_result(ist_pkg::in_word_t w);
        ist_pkg::out_word_t r;
        int i;
        r = '0;
        case (ist_pkg::mode_t'(w.mode))
            ist_pkg::MODE_ADD:
                r.status = table_add(w.start_offset, w.end_offset, w.evict_lowest);
            ist_pkg::MODE_REMOVE:
                r.status = table_remove(w.start_offset, w.end_offset);
            ist_pkg::MODE_TRIM: begin
                i = 0;
                while (i < tbl_count && tbl_hi[i] <= w.start_offset) i++;
                drop_range(0, i);
                if (tbl_count > 0 && tbl_lo[0] < w.start_offset)
                    tbl_lo[0] = w.start_offset;
            end
            ist_pkg::MODE_CONTAINS: begin
                i = first_reaching(w.start_offset);
                r.answer = i < tbl_count && tbl_lo[i] <= w.start_offset
                    && w.start_offset < tbl_hi[i];
            end
            ist_pkg::MODE_COVERS: begin
                if (w.start_offset >= w.end_offset) begin
                    r.answer = 1'b1;
                end else begin
                    i = first_reaching(w.start_offset);
                    r.answer = i < tbl_count && tbl_lo[i] <= w.start_offset
                        && w.end_offset <= tbl_hi[i];
                end
            end
            ist_pkg::MODE_POP: begin
                if (tbl_count > 0 && w.length_limit != 0) begin
                    r.answer = 1'b1;
                    r.out_start = tbl_lo[0];
                    if (tbl_hi[0] - tbl_lo[0] <= w.length_limit) begin
                        r.out_end = tbl_hi[0];
                        drop_range(0, 1);
                    end else begin
                        r.out_end = tbl_lo[0] + w.length_limit;
                        tbl_lo[0] = r.out_end;
                    end
                end
            end
            ist_pkg::MODE_CLEAR: tbl_count = 0;
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("Mismatch in %s: got %h, expected %h", what, got, want);
        fail_count++;
    endtask

    // Sends one word and records its expected result at acceptance.
    // Valid drops after each accepted word.
    task automatic send_word(ist_pkg::in_word_t w);
        repeat (gap_len()) @(posedge aclk);
        s_valid <= 1'b1;
        s_word <= w;
        do @(posedge aclk); while (!s_ready);
        expected_words.push_back(predict_result(w));
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_op(ist_pkg::mode_t m, logic [63:0] a, logic [63:0] b,
                           logic ev = 1'b0, logic [63:0] len = 64'd0);
        ist_pkg::in_word_t w;
        w.mode = m;
        w.start_offset = a;
        w.end_offset = b;
        w.evict_lowest = ev;
        w.length_limit = len;
        send_word(w);
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (2 * DEPTH + 20) @(posedge aclk);
    endtask

    task automatic write_limit(int value);
        cfg_we <= 1'b1;
        cfg_wdata <= value[ist_pkg::CFG_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        tbl_limit_reg = value & 6'h3f;
    endtask

    // Result stalls and checking.
    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(0, 99) < 10) ? 1'b0 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        ist_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", m_word.out_start, 64'd0);
            end else begin
                want = expected_words.pop_front();
                if (m_word.status !== want.status)
                    report_mismatch("status", m_word.status, want.status);
                if (m_word.answer !== want.answer)
                    report_mismatch("answer", m_word.answer, want.answer);
                if (m_word.out_start !== want.out_start)
                    report_mismatch("out_start", m_word.out_start, want.out_start);
                if (m_word.out_end !== want.out_end)
                    report_mismatch("out_end", m_word.out_end, want.out_end);
            end
        end
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_directed();
        send_op(ist_pkg::MODE_POP, 0, 0, 0, 5);
        send_op(ist_pkg::MODE_ADD, 10, 20);
        send_op(ist_pkg::MODE_ADD, 20, 30);
        send_op(ist_pkg::MODE_ADD, 5, 5);
        send_op(ist_pkg::MODE_ADD, 9, 3);
        send_op(ist_pkg::MODE_ADD, 40, 50);
        send_op(ist_pkg::MODE_ADD, 64'hffff_ffff_ffff_fff0, 64'hffff_ffff_ffff_ffff, 1'b1);
        send_op(ist_pkg::MODE_CONTAINS, 15, 0);
        send_op(ist_pkg::MODE_CONTAINS, 30, 0);
        send_op(ist_pkg::MODE_COVERS, 12, 28);
        send_op(ist_pkg::MODE_COVERS, 25, 45);
        send_op(ist_pkg::MODE_COVERS, 7, 7);
        send_op(ist_pkg::MODE_REMOVE, 14, 16);
        send_op(ist_pkg::MODE_REMOVE, 0, 64'hffff_ffff_ffff_ffff);
        send_op(ist_pkg::MODE_ADD, 0, 100);
        send_op(ist_pkg::MODE_TRIM, 30, 0);
        send_op(ist_pkg::MODE_POP, 0, 0, 0, 0);
        send_op(ist_pkg::MODE_POP, 0, 0, 0, 7);
        send_op(ist_pkg::MODE_POP, 0, 0, 0, 64'hffff_ffff_ffff_ffff);
        send_op(ist_pkg::MODE_NONE, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                1'b1, 64'hffff_ffff_ffff_ffff);
        send_op(ist_pkg::MODE_CLEAR, 0, 0);
        wait_drained();
    endtask

    // Small limit: fills the table, then exercises eviction and split failure.
    task automatic test_small_limit();
        write_limit(2);
        send_op(ist_pkg::MODE_ADD, 100, 110);
        send_op(ist_pkg::MODE_ADD, 200, 210);
        send_op(ist_pkg::MODE_ADD, 300, 310);
        send_op(ist_pkg::MODE_ADD, 50, 60, 1'b1);
        send_op(ist_pkg::MODE_ADD, 300, 310, 1'b1);
        send_op(ist_pkg::MODE_REMOVE, 302, 305);
        wait_drained();
        write_limit(0);
        send_op(ist_pkg::MODE_ADD, 500, 510);
        send_op(ist_pkg::MODE_CLEAR, 0, 0);
        wait_drained();
    endtask

    // Random words in a small window so that intervals interact.
    task automatic run_random(int count, int span);
        ist_pkg::in_word_t w;
        logic [63:0] base;
        for (int n = 0; n < count; n++) begin
            base = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : 64'd1000;
            w.start_offset = base + $urandom_range(0, span);
            w.end_offset = w.start_offset + $urandom_range(0, 12) - 2;
            if ($urandom_range(0, 19) == 0) w.end_offset = {$urandom, $urandom};
            w.evict_lowest = $urandom_range(0, 1);
            w.length_limit = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                             : 64'($urandom_range(0, 6));
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: w.mode = ist_pkg::MODE_ADD;
                8, 9, 10: w.mode = ist_pkg::MODE_REMOVE;
                11: w.mode = ist_pkg::MODE_TRIM;
                12, 13: w.mode = ist_pkg::MODE_CONTAINS;
                14, 15: w.mode = ist_pkg::MODE_COVERS;
                16, 17: w.mode = ist_pkg::MODE_POP;
                18: w.mode = ($urandom_range(0, 3) == 0) ? ist_pkg::MODE_CLEAR
                                                         : ist_pkg::MODE_ADD;
                default: w.mode = ($urandom_range(0, 1) != 0) ? ist_pkg::MODE_NONE
                                                              : ist_pkg::MODE_POP;
            endcase
            send_word(w);
        end
    endtask

    task automatic test_random();
        int limits[5] = '{32, 1, 5, 63, 17};
        foreach (limits[k]) begin
            write_limit(limits[k]);
            run_random(100, 300);
            // Hold off until the block has answered everything.
            while (expected_words.size() != 0) @(posedge aclk);
            run_random(110, 150);
            wait_drained();
        end
    endtask

    initial begin
        tbl_count = 0;
        tbl_limit_reg = 32;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_small_limit();
        test_random();
        wait_drained();
        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
